// ===== sv/irc_mfs_pkg.sv =====
// ----------------------------------------------------------------------------
// irc_mfs_pkg
// Shared types, codes and helpers for the IRC message field splitter.
// ----------------------------------------------------------------------------
package irc_mfs_pkg;

    // field tags
    localparam logic [2:0] TAG_DROP   = 3'd0;
    localparam logic [2:0] TAG_PREFIX = 3'd1;
    localparam logic [2:0] TAG_CMD    = 3'd2;
    localparam logic [2:0] TAG_PARAMS = 3'd3;
    localparam logic [2:0] TAG_TRAIL  = 3'd4;

    // line error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_LONG  = 2'd1;
    localparam logic [1:0] ERR_SPACE = 2'd2;
    localparam logic [1:0] ERR_NOCMD = 2'd3;

    // characters and limits
    localparam logic [7:0] CHAR_COLON    = 8'h3A;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [7:0] CHAR_TAB      = 8'h09;
    localparam logic [7:0] CHAR_CR       = 8'h0D;
    localparam logic [9:0] CNT_MAX       = 10'd1023;
    localparam logic [9:0] MAX_LEN_RESET = 10'd510;

    // one input request
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_req;

    // one result
    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] field_tag;
        logic [9:0] held_spaces;
        logic       out_last;
        logic [1:0] error_code;
    } t_res;

    // space, tab, newline, vertical tab, form feed, carriage return
    function automatic logic is_white(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

endpackage

// ===== sv/irc_message_field_splitter_core.sv =====
// ----------------------------------------------------------------------------
// irc_message_field_splitter_core
// Tags each byte of an IRC-style message line with the field it belongs to.
// ----------------------------------------------------------------------------
// The block takes one byte per clock while o_stall is low and returns one
// result per byte. An accepted request's result goes to the output register,
// or to the skid stage behind it while the output register is stalled, so
// the block can take a request while an earlier result is still stalled;
// o_stall rises only when both are full. The only work per byte is the
// parse-mode and counter update, which sits between the line state registers
// and the output register. Line state returns to start after the byte marked
// last. max_length may be written only while no request is in flight.
module irc_message_field_splitter_core
    import irc_mfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [9:0] i_cfg_wr_data,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_req       i_req,
    output logic       o_valid,
    input  logic       i_stall,
    output t_res       o_res
);

    typedef enum logic [2:0] {
        MODE_START    = 3'd0,
        MODE_PFX_OPEN = 3'd1,
        MODE_PREFIX   = 3'd2,
        MODE_PFX_SP   = 3'd3,
        MODE_CMD      = 3'd4,
        MODE_CMD_SP   = 3'd5,
        MODE_PARAMS   = 3'd6,
        MODE_TRAILING = 3'd7
    } t_mode;

    t_mode      r_mode,     n_mode;
    logic [9:0] r_pend,     n_pend;
    logic [9:0] r_count,    n_count;
    logic [1:0] r_err,      n_err;
    logic [9:0] r_max_len;
    logic       r_out_valid;
    t_res       r_out;
    logic       r_skid_valid;
    t_res       r_skid;
    t_res       n_res;

    logic       in_acc;
    logic       out_take;

    // handshakes
    assign in_acc   = i_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_stall;
    assign o_stall  = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_res    = r_out;

    // per-byte parse step
    always_comb begin
        logic [2:0] tag;
        logic [9:0] held;
        logic [7:0] c;
        tag     = TAG_DROP;
        held    = '0;
        c       = i_req.in_byte;
        n_mode  = r_mode;
        n_pend  = r_pend;
        n_err   = r_err;
        n_count = (r_count == CNT_MAX) ? r_count : r_count + 10'd1;

        // length check first
        if ((n_err == ERR_NONE) && (n_count >= r_max_len)) begin
            n_err = ERR_LONG;
        end

        if (n_err == ERR_NONE) begin
            unique case (r_mode)
                MODE_START: begin
                    if (c == CHAR_COLON) begin
                        n_mode = MODE_PFX_OPEN;
                    end else if (c == CHAR_SPACE) begin
                        n_mode = MODE_CMD_SP;
                    end else begin
                        tag    = TAG_CMD;
                        n_mode = MODE_CMD;
                    end
                end
                MODE_PFX_OPEN: begin
                    if (is_white(c)) begin
                        n_err = ERR_SPACE;
                    end else begin
                        tag    = TAG_PREFIX;
                        n_mode = MODE_PREFIX;
                    end
                end
                MODE_PREFIX: begin
                    if (c == CHAR_SPACE) begin
                        n_mode = MODE_PFX_SP;
                    end else begin
                        tag = TAG_PREFIX;
                    end
                end
                MODE_PFX_SP: begin
                    if (c != CHAR_SPACE) begin
                        tag    = TAG_CMD;
                        n_mode = MODE_CMD;
                    end
                end
                MODE_CMD: begin
                    if (c == CHAR_SPACE) begin
                        n_mode = MODE_CMD_SP;
                    end else begin
                        tag = TAG_CMD;
                    end
                end
                MODE_CMD_SP: begin
                    if (c == CHAR_COLON) begin
                        n_mode = MODE_TRAILING;
                    end else if (c != CHAR_SPACE) begin
                        tag    = TAG_PARAMS;
                        n_pend = '0;
                        n_mode = MODE_PARAMS;
                    end
                end
                MODE_PARAMS: begin
                    if (c == CHAR_SPACE) begin
                        if (r_pend != CNT_MAX) begin
                            n_pend = r_pend + 10'd1;
                        end
                    end else if ((c == CHAR_COLON) && (r_pend != '0)) begin
                        n_pend = '0;
                        n_mode = MODE_TRAILING;
                    end else begin
                        tag    = TAG_PARAMS;
                        held   = r_pend;
                        n_pend = '0;
                    end
                end
                MODE_TRAILING: begin
                    tag = TAG_TRAIL;
                end
            endcase
            if (n_err != ERR_NONE) begin
                tag  = TAG_DROP;
                held = '0;
            end
        end

        // line ended before any command
        if (i_req.in_last && (n_err == ERR_NONE) &&
            ((n_mode == MODE_PFX_OPEN) || (n_mode == MODE_PREFIX) ||
             (n_mode == MODE_PFX_SP))) begin
            n_err = ERR_NOCMD;
            tag   = TAG_DROP;
            held  = '0;
        end

        n_res.out_byte    = c;
        n_res.field_tag   = tag;
        n_res.held_spaces = held;
        n_res.out_last    = i_req.in_last;
        n_res.error_code  = n_err;

        // back to start of line after the last byte
        if (i_req.in_last) begin
            n_mode  = MODE_START;
            n_pend  = '0;
            n_count = '0;
            n_err   = ERR_NONE;
        end
    end

    // line state, config, output register and skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_START;
            r_pend       <= '0;
            r_count      <= '0;
            r_err        <= ERR_NONE;
            r_max_len    <= MAX_LEN_RESET;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_len <= i_cfg_wr_data;
            end
            if (in_acc) begin
                r_mode  <= n_mode;
                r_pend  <= n_pend;
                r_count <= n_count;
                r_err   <= n_err;
            end
            if (!r_out_valid || out_take) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else if (in_acc) begin
                    r_out       <= n_res;
                    r_out_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (in_acc) begin
                r_skid       <= n_res;
                r_skid_valid <= 1'b1;
            end
        end
    end

endmodule

// ===== sv/irc_mfs_checker.sv =====
// ----------------------------------------------------------------------------
// irc_mfs_checker
// Port-level checks for the IRC message field splitter, bound to the core.
// ----------------------------------------------------------------------------
module irc_mfs_checker
    import irc_mfs_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cfg_wr_en,
    input logic [9:0] i_cfg_wr_data,
    input logic       i_valid,
    input logic       o_stall,
    input t_req       i_req,
    input logic       o_valid,
    input logic       i_stall,
    input t_res       o_res
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_res))
        else $error("stalled result changed");

    // no result right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // an errored line drops its bytes
    a_err_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_res.error_code != ERR_NONE) |-> o_res.field_tag == TAG_DROP)
        else $error("byte tagged despite line error");

    // held spaces only go with params bytes
    a_held_params: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_res.field_tag != TAG_PARAMS) |-> o_res.held_spaces == '0)
        else $error("held spaces on non-params byte");

    // tag stays in its code range
    a_tag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_res.field_tag <= TAG_TRAIL)
        else $error("field tag out of range");

endmodule

bind irc_message_field_splitter_core irc_mfs_checker u_irc_mfs_checker (.*);
